FILE: rtl/core/cma_pkg.sv
// Shared types and constants for the causal moving average block.
package cma_pkg;

    // Width of the window size configuration register.
    localparam int WIN_W = 7;

    // Sequencer state encoding.
    typedef logic [1:0] state_t;

    localparam state_t ST_IDLE = 2'd0;
    localparam state_t ST_ADJ  = 2'd1;
    localparam state_t ST_DIV  = 2'd2;

endpackage

FILE: rtl/core/causal_moving_average.sv
// Causal moving average: ring memory, running-sum sequencer and divider.
// Each sample is accepted in idle, its running sum is adjusted by the R ring reads
// it needs (one in steady state, up to MAX_WINDOW after a window change), and it is
// handed to the divider; only then is a new sample taken, so output stalls that hold
// the divider also hold the input. The sum is SAMPLE_WIDTH + clog2(MAX_WINDOW) bits.
// Reset clears control state and sets the window to 1; the ring is not cleared.
module causal_moving_average #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           first_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] average,
    input  logic                           cfg_write_en,
    input  logic [cma_pkg::WIN_W-1:0]      cfg_write_data
);

    import cma_pkg::*;

    // Ring pointer, sample count, coverage count (may briefly reach MAX_WINDOW + 1)
    // and running sum widths. The sum may wrap while it is being adjusted, but the
    // final value of every item always fits.
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int COV_W = $clog2(MAX_WINDOW + 2);
    localparam int OFF_W = COV_W + 1;
    localparam int SUM_W = SAMPLE_WIDTH + PTR_W;
    localparam int EXT_W = (WIN_W > CNT_W) ? WIN_W : CNT_W;

    // Sequencer state. The running sum covers cov_reg ring entries ending at the
    // newest sample; in idle cov_reg equals the window length of the last result.
    state_t            state_reg,   state_next;
    logic [PTR_W-1:0]  wp_reg,      wp_next;
    logic [PTR_W-1:0]  newest_reg,  newest_next;
    logic [CNT_W-1:0]  fill_reg,    fill_next;
    logic [CNT_W-1:0]  n_reg,       n_next;
    logic [COV_W-1:0]  cov_reg,     cov_next;
    logic [SUM_W-1:0]  sum_reg,     sum_next;
    logic              pend_reg,    pend_next;
    logic              pend_sub_reg, pend_sub_next;
    logic [CNT_W-1:0]  win_eff_reg, win_eff_next;

    logic              accept;
    logic [CNT_W-1:0]  fill_base;
    logic [COV_W-1:0]  cov_base;
    logic [SUM_W-1:0]  sum_base;
    logic [CNT_W-1:0]  fill_new;
    logic [CNT_W-1:0]  n_new;
    logic [COV_W-1:0]  cov0;
    logic [SUM_W-1:0]  sample_ext;
    logic [EXT_W-1:0]  cfg_ext;

    // Read planning: which ring entry joins or leaves the sum next.
    logic [COV_W-1:0]  plan_cov;
    logic [CNT_W-1:0]  plan_n;
    logic [PTR_W-1:0]  plan_newest;
    logic [COV_W-1:0]  plan_n_ext;
    logic              plan_sub;
    logic              plan_add;
    logic              plan_rd;
    logic [COV_W-1:0]  plan_off;
    logic [OFF_W-1:0]  plan_diff;
    logic [PTR_W-1:0]  plan_addr;
    logic [COV_W-1:0]  plan_cov_after;

    logic [SAMPLE_WIDTH-1:0] ram_rdata;
    logic [SUM_W-1:0]        rd_ext;
    logic [SUM_W-1:0]        sum_adj;
    logic                    ram_re;

    // Divider request.
    logic              div_valid;
    logic              div_ready;
    logic              div_neg;
    logic [SUM_W-1:0]  div_mag;
    logic [SUM_W-1:0]  div_dividend;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // A zero window acts as one, and anything past the ring depth as the ring depth.
    assign cfg_ext = EXT_W'(cfg_write_data);

    always_comb
    begin
        priority if (cfg_write_data == '0)
        begin
            win_eff_next = CNT_W'(1);
        end
        else if (cfg_ext > EXT_W'(MAX_WINDOW))
        begin
            win_eff_next = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff_next = CNT_W'(cfg_ext);
        end
    end

    // A first-sample beat drops the running sum and starts counting from zero.
    assign fill_base  = first_sample ? '0 : fill_reg;
    assign cov_base   = first_sample ? '0 : cov_reg;
    assign sum_base   = first_sample ? '0 : sum_reg;
    assign fill_new   = (fill_base == CNT_W'(MAX_WINDOW)) ? fill_base
                                                          : fill_base + CNT_W'(1);
    assign n_new      = (win_eff_reg < fill_new) ? win_eff_reg : fill_new;
    assign cov0       = cov_base + COV_W'(1);
    assign sample_ext = {{(SUM_W - SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};

    // In idle the plan looks at the beat being accepted; afterwards at the item in work.
    assign plan_cov    = (state_reg == ST_IDLE) ? cov0     : cov_reg;
    assign plan_n      = (state_reg == ST_IDLE) ? n_new    : n_reg;
    assign plan_newest = (state_reg == ST_IDLE) ? wp_reg   : newest_reg;
    assign plan_n_ext  = COV_W'(plan_n);

    // Too many entries covered: drop the oldest one. Too few: add the next older one.
    // The oldest entry may be the slot written this same cycle when the window is
    // full; the ring returns the old contents then.
    assign plan_sub = plan_cov > plan_n_ext;
    assign plan_add = plan_cov < plan_n_ext;
    assign plan_rd  = plan_sub || plan_add;
    assign plan_off = plan_sub ? plan_cov - COV_W'(1) : plan_cov;
    assign plan_diff = OFF_W'(plan_newest) - OFF_W'(plan_off);
    assign plan_addr = plan_diff[OFF_W-1] ? PTR_W'(plan_diff + OFF_W'(MAX_WINDOW))
                                          : PTR_W'(plan_diff);
    assign plan_cov_after = plan_sub ? plan_cov - COV_W'(1) : plan_cov + COV_W'(1);

    assign ram_re = plan_rd && (accept || (state_reg == ST_ADJ));

    cma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (ram_re),
        .raddr (plan_addr),
        .rdata (ram_rdata)
    );

    // The ring entry read last cycle is applied to the sum now.
    assign rd_ext  = {{(SUM_W - SAMPLE_WIDTH){ram_rdata[SAMPLE_WIDTH-1]}}, ram_rdata};
    assign sum_adj = pend_sub_reg ? sum_reg - rd_ext : sum_reg + rd_ext;

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        newest_next   = newest_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        cov_next      = cov_reg;
        sum_next      = sum_reg;
        pend_next     = pend_reg;
        pend_sub_next = pend_sub_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fill_next     = fill_new;
                    n_next        = n_new;
                    sum_next      = sum_base + sample_ext;
                    newest_next   = wp_reg;
                    wp_next       = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0
                                                                       : wp_reg + PTR_W'(1);
                    cov_next      = plan_rd ? plan_cov_after : cov0;
                    pend_next     = plan_rd;
                    pend_sub_next = plan_sub;
                    state_next    = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_adj;
                end
                cov_next      = plan_rd ? plan_cov_after : cov_reg;
                pend_next     = plan_rd;
                pend_sub_next = plan_sub;
                state_next    = plan_rd ? ST_ADJ : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            newest_reg   <= '0;
            fill_reg     <= '0;
            n_reg        <= '0;
            cov_reg      <= '0;
            sum_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_sub_reg <= 1'b0;
            win_eff_reg  <= CNT_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            newest_reg   <= newest_next;
            fill_reg     <= fill_next;
            n_reg        <= n_next;
            cov_reg      <= cov_next;
            sum_reg      <= sum_next;
            pend_reg     <= pend_next;
            pend_sub_reg <= pend_sub_next;
            if (cfg_write_en)
            begin
                win_eff_reg <= win_eff_next;
            end
        end
    end

    // Round to nearest with ties away from zero: divide |sum| + floor(n/2) by n
    // and put the sign back afterwards.
    assign div_valid    = (state_reg == ST_DIV);
    assign div_neg      = sum_reg[SUM_W-1];
    assign div_mag      = div_neg ? SUM_W'(0) - sum_reg : sum_reg;
    assign div_dividend = div_mag + SUM_W'(n_reg >> 1);

    cma_div #(
        .MAG_W (SUM_W),
        .DIV_W (CNT_W),
        .OUT_W (SAMPLE_WIDTH)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (div_valid),
        .req_ready    (div_ready),
        .req_dividend (div_dividend),
        .req_divisor  (n_reg),
        .req_neg      (div_neg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average)
    );

endmodule

FILE: rtl/core/cma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/cma_div.sv
// Pipelined restoring divider with sign restore and an output register.
module cma_div #(
    parameter int MAG_W = 22,
    parameter int DIV_W = 7,
    parameter int OUT_W = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [MAG_W-1:0]        req_dividend,
    input  logic [DIV_W-1:0]        req_divisor,
    input  logic                    req_neg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] average
);

    // Stage 0 holds the request; each later stage resolves one quotient bit.
    logic [DIV_W-1:0] rem_reg [MAG_W+1];
    logic [MAG_W-1:0] dq_reg  [MAG_W+1];
    logic [DIV_W-1:0] dv_reg  [MAG_W+1];
    logic             neg_reg [MAG_W+1];
    logic [MAG_W:0]   vld_reg;

    logic [DIV_W-1:0] step_rem [MAG_W];
    logic [MAG_W-1:0] step_dq  [MAG_W];
    logic [DIV_W:0]   step_tmp [MAG_W];
    logic [MAG_W-1:0] step_ge;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] average_reg;
    logic [OUT_W-1:0]        result;
    logic                    adv;

    // The whole pipe moves together whenever the output register can take a beat.
    assign adv       = !out_valid_reg || out_ready;
    assign req_ready = adv;

    always_comb
    begin
        for (int k = 0; k < MAG_W; k++)
        begin
            step_tmp[k] = {rem_reg[k], dq_reg[k][MAG_W-1]};
            step_ge[k]  = step_tmp[k] >= {1'b0, dv_reg[k]};
            step_rem[k] = step_ge[k] ? DIV_W'(step_tmp[k] - {1'b0, dv_reg[k]})
                                     : DIV_W'(step_tmp[k]);
            step_dq[k]  = {dq_reg[k][MAG_W-2:0], step_ge[k]};
        end
    end

    assign result = neg_reg[MAG_W] ? OUT_W'(MAG_W'(0) - dq_reg[MAG_W])
                                   : OUT_W'(dq_reg[MAG_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[MAG_W-1:0], req_valid};
            out_valid_reg <= vld_reg[MAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= req_dividend;
            dv_reg[0]  <= req_divisor;
            neg_reg[0] <= req_neg;
            for (int k = 0; k < MAG_W; k++)
            begin
                rem_reg[k+1] <= step_rem[k];
                dq_reg[k+1]  <= step_dq[k];
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
            average_reg <= signed'(result);
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

endmodule

FILE: rtl/core/cma_checker.sv
// Port-level checks for the causal moving average, bound to the top level.
module cma_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] average
);

    // Beats taken in whose result has not yet been delivered.
    logic [7:0] pend_cnt_reg, pend_cnt_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        if (in_beat && !out_beat)
        begin
            pend_cnt_next = pend_cnt_reg + 8'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pend_cnt_next = pend_cnt_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // A result is only ever offered for a sample that was taken in.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_cnt_reg != 8'd0)
        else $error("result offered with no sample outstanding");

    // A stalled result keeps its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average))
        else $error("stalled result changed or vanished");

    // The sequencer works on one sample at a time, so two beats never come back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on two consecutive cycles");

endmodule

bind causal_moving_average cma_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average)
);

FILE: tb/sv/causal_moving_average_test.sv
// Self-checking testbench for the causal moving average block.
`timescale 1ns / 100ps

module causal_moving_average_test;

    localparam int MAX_WINDOW      = 64;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int SLOT_W          = $clog2(MAX_WINDOW);
    // Worst quiet stretch of a correct run: a full ring rescan after a window change,
    // the divider latency and the longest receiver stall, taken many times over.
    localparam int IDLE_LIMIT      = 2000;
    // After the last average we keep listening for DRAIN_CYCLES to catch any stray
    // output beat.
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_PHASES   = 12;
    localparam int BEATS_PER_PHASE = 170;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [cma_pkg::WIN_W-1:0]      window_t;

    // Receiver behaviors; the receiver picks one of them at random at regular intervals.
    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

    // One row of the directed table. A row either programs a new window before its
    // beat (win >= 0) or keeps the current one. Rows with pinned set carry the average
    // that the beat must produce; all other rows are checked against the predictor.
    typedef struct {
        int      win;
        sample_t smp;
        bit      first;
        bit      pinned;
        sample_t avg;
    } stim_row_t;

    logic    clk            = 1'b0;
    logic    rst_n          = 1'b0;
    logic    in_valid       = 1'b0;
    logic    in_ready;
    sample_t sample         = '0;
    logic    first_sample   = 1'b0;
    logic    out_valid;
    logic    out_ready      = 1'b0;
    sample_t average;
    logic    cfg_write_en   = 1'b0;
    window_t cfg_write_data = '0;

    // Travels alongside the input beat so the monitor knows whether the table
    // supplies the expected average for it.
    logic    pinned_en  = 1'b0;
    sample_t pinned_avg = '0;

    // Predictor state, matching the block right after reset.
    sample_t             history [MAX_WINDOW];
    window_t             window_reg = 1;
    int                  seq_fill   = 0;
    logic [SLOT_W-1:0]   slot       = '0;

    sample_t   avg_expected [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;

    // Sender pacing: beats go out in bursts; tx_steady turns the gaps off.
    int        burst_left = 0;
    bit        tx_steady  = 1'b0;

    // Receiver pattern state.
    rx_mode_t  rx_mode    = RX_OPEN;
    int        rx_cycle   = 0;
    int        stall_left = 0;

    window_t   corner_windows [5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};

    causal_moving_average #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .first_sample   (first_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .average        (average),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advances the predictor by one accepted sample and returns the rounded mean of
    // the newest n samples of the sequence. A zero window counts as one and any
    // window above the ring depth counts as the full ring. The sum is rebuilt from
    // the ring every time, so a window that shrinks mid-sequence is handled exactly.
    function automatic sample_t predict_average(input sample_t smp, input bit first);
        int                span;
        int                total;
        int                mag;
        int                quot;
        logic [SLOT_W-1:0] idx;
        if (first)
            seq_fill = 0;
        history[slot] = smp;
        idx  = slot;
        slot = slot + 1'b1;
        if (seq_fill < MAX_WINDOW)
            seq_fill++;
        if (window_reg == 0)
            span = 1;
        else if (window_reg > MAX_WINDOW)
            span = MAX_WINDOW;
        else
            span = int'(window_reg);
        if (span > seq_fill)
            span = seq_fill;
        total = 0;
        for (int k = 0; k < span; k++)
        begin
            total += history[idx];
            idx = idx - 1'b1;
        end
        // Round half away from zero: work on the magnitude, then restore the sign.
        mag  = (total < 0) ? -total : total;
        quot = (mag + span / 2) / span;
        return sample_t'((total < 0) ? -quot : quot);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic void add_row(input int win, input int smp, input bit first,
                                    input bit pinned, input int avg);
        stim_row_t row;
        row.win    = win;
        row.smp    = sample_t'(smp);
        row.first  = first;
        row.pinned = pinned;
        row.avg    = sample_t'(avg);
        directed_rows = {directed_rows, row};
    endfunction

    // Samples are mostly full-range random, with the two extremes and values near zero
    // mixed in so that rounding ties and saturated sums come up often.
    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(16'h7FFF);
            1:       return sample_t'(16'h8000);
            2, 3:    return sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Presents one input beat and returns at the edge where it is accepted. Before a
    // new burst the sender may drop valid for a random gap; inside a burst valid stays
    // high from beat to beat, so no step lowers and raises it.
    task automatic drive_beat(input sample_t smp, input bit first,
                              input bit pin, input sample_t pavg);
        int gap;
        if (burst_left == 0)
        begin
            gap        = tx_steady ? 0 : int'($urandom_range(0, 12));
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        sample       <= smp;
        first_sample <= first;
        pinned_en    <= pin;
        pinned_avg   <= pavg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every expected average has come back, so the
    // block is idle. The first edge lets the monitor record a beat accepted just now.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (avg_expected.size() != 0);
    endtask

    task automatic write_window(input window_t value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Monitor: tracks window writes, predicts an average for every accepted input
    // beat and checks every accepted output beat against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        sample_t expected;
        if (rst_n)
        begin
            if (cfg_write_en)
                window_reg = cfg_write_data;
            if (in_valid && in_ready)
            begin
                expected = predict_average(sample, first_sample);
                if (pinned_en)
                    expected = pinned_avg;
                avg_expected = {avg_expected, expected};
            end
            if (out_valid && out_ready)
            begin
                if (avg_expected.size() == 0)
                    report_mismatch($sformatf("average %0d with no input beat pending",
                                              average));
                else
                begin
                    expected = avg_expected.pop_front();
                    if (average !== expected)
                        report_mismatch($sformatf("average %0d, expected %0d",
                                                  average, expected));
                end
            end
        end
    end

    // Receiver: each mode gives the output a different stall rhythm, including long
    // stalls and stretches where it never stalls.
    always @(posedge clk)
    begin : receiver
        logic ready_next;
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        ready_next = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:     ready_next = 1'b1;
                RX_RANDOM:   ready_next = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: ready_next = (rx_cycle % 3 == 0);
                RX_BURSTY:
                begin
                    if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(10, 40);
                end
            endcase
        end
        out_ready <= ready_next;
    end

    // Watchdog: a correct block always moves some beat well within the limit.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int seq_left;
        bit starts_seq;
        seq_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The very first beat has its flag low: right after reset the
        // fill count is zero, so it still opens a sequence.
        add_row(-1,  32767, 1'b0, 1'b1,  32767);
        add_row(-1, -32768, 1'b0, 1'b1, -32768);
        add_row(-1,      0, 1'b1, 1'b1,      0);
        // A zero window behaves as a window of one.
        add_row( 0,  12345, 1'b0, 1'b1,  12345);
        add_row(-1,     -1, 1'b0, 1'b1,     -1);
        // Window of two: exact halves round away from zero on both signs.
        add_row( 2,      1, 1'b1, 1'b1,      1);
        add_row(-1,      2, 1'b0, 1'b1,      2);
        add_row(-1,     -3, 1'b0, 1'b1,     -1);
        add_row(-1,  32767, 1'b1, 1'b1,  32767);
        add_row(-1,  32767, 1'b0, 1'b1,  32767);
        add_row(-1, -32768, 1'b0, 1'b1,     -1);
        // A window above the ring depth is clamped to the ring depth.
        add_row(127, 32767, 1'b1, 1'b1,  32767);
        add_row(-1, -32768, 1'b0, 1'b1,     -1);
        add_row(64,      1, 1'b1, 1'b1,      1);
        add_row(65,      3, 1'b0, 1'b1,      2);
        add_row(-1,      5, 1'b0, 1'b0,      0);
        // Window changes, some in the middle of a sequence, growing and shrinking.
        add_row( 3,     10, 1'b0, 1'b0,      0);
        add_row(-1,    -20, 1'b0, 1'b0,      0);
        add_row( 1,     -7, 1'b1, 1'b1,     -7);
        add_row( 4,     -2, 1'b1, 1'b1,     -2);
        add_row(-1,     -1, 1'b0, 1'b0,      0);
        add_row(-1,     -4, 1'b0, 1'b0,      0);
        add_row( 2,    100, 1'b0, 1'b0,      0);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].win >= 0)
            begin
                settle();
                write_window(window_t'(directed_rows[r].win));
            end
            drive_beat(directed_rows[r].smp, directed_rows[r].first,
                       directed_rows[r].pinned, directed_rows[r].avg);
        end

        // Random phases: the first ones use the corner windows, the rest mostly small
        // windows with an occasional large or oversized one. Sequences of random length
        // run across phase boundaries, so window changes also land mid-sequence.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase < 5)
                write_window(corner_windows[phase]);
            else if ($urandom_range(0, 2) != 0)
                write_window(window_t'($urandom_range(1, 8)));
            else
                write_window(window_t'($urandom_range(0, 127)));
            tx_steady = (phase % 4 == 3);
            for (int b = 0; b < BEATS_PER_PHASE; b++)
            begin
                // Once, hold the sender back until the pipeline has fully drained.
                if (phase == 6 && b == BEATS_PER_PHASE / 2)
                    settle();
                if (seq_left == 0)
                begin
                    starts_seq = 1'b1;
                    seq_left   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3))
                                                            : int'($urandom_range(4, 100));
                end
                else
                    starts_seq = ($urandom_range(0, 19) == 0);
                seq_left--;
                drive_beat(random_sample(), starts_seq, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: causal_moving_average.f
rtl/core/cma_pkg.sv
rtl/core/cma_ram.sv
rtl/core/cma_div.sv
rtl/core/causal_moving_average.sv
rtl/core/cma_checker.sv
tb/sv/causal_moving_average_test.sv
